// ===== rtl/longest_interval_keeper_assert.svh =====
// Assertion macros used by the checker file of the interval keeper.
`ifndef LONGEST_INTERVAL_KEEPER_ASSERT_SVH
`define LONGEST_INTERVAL_KEEPER_ASSERT_SVH

// Concurrent check, masked while reset is asserted.
`define LIK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("interval keeper assertion failed");

// Concurrent check that also covers the reset cycles.
`define LIK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("interval keeper reset assertion failed");

`endif

// ===== rtl/lik_pkg.sv =====
// Types and codes shared by the interval keeper modules.
package lik_pkg;

  localparam int BEGIN_W = 12;
  localparam int END_W   = 13;
  localparam int COUNT_W = 13;

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_QUERY     = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;
  localparam logic [1:0] OP_QUERY_ALT = 2'd3;

  localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
  localparam logic [2:0] STAT_REJECTED  = 3'd1;
  localparam logic [2:0] STAT_BAD_RANGE = 3'd2;
  localparam logic [2:0] STAT_QUERY     = 3'd3;
  localparam logic [2:0] STAT_CLEARED   = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [BEGIN_W-1:0] interval_begin;
    logic [END_W-1:0]   interval_end;
    logic [1:0]         reading_phase;
    logic               strand_reverse;
    logic signed [31:0] orf_score;
    logic [BEGIN_W-1:0] query_position;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COUNT_W-1:0] evicted_count;
    logic               owner_valid;
    logic [BEGIN_W-1:0] owner_begin;
    logic [END_W-1:0]   owner_end;
    logic [1:0]         owner_phase;
    logic               owner_strand;
    logic signed [31:0] owner_score;
  } out_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [BEGIN_W-1:0] first;
    logic [END_W-1:0]   past;
    logic [1:0]         phase;
    logic               strand;
    logic signed [31:0] score;
  } map_entry_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_QUERY,
    S_CHECK,
    S_WRITE
  } state_t;

endpackage

// ===== rtl/lik_owner_map.sv =====
// Owner map storage: one write port, one read port with registered read data.
module lik_owner_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  lik_pkg::map_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output lik_pkg::map_entry_t rd_data
);

  lik_pkg::map_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/longest_interval_keeper.sv =====
// Interval keeper, one request at a time: busy is low again when the result shows.
// A query reads the map entry then answers; a bad range answers without leaving idle; clear sweeps the map.
// An insert checks each position of its range, then writes its write span (new range plus
// evicted overhang) and answers; a check that finds a longer owner rejects at that position.
// Reset (synchronous, rst_n low): busy for a clearing sweep of the whole map.
module longest_interval_keeper #(
  parameter int SEQ_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lik_pkg::in_req_t  in_req,
  output logic              out_valid,
  output lik_pkg::out_rsp_t out_rsp
);

  localparam int AW = $clog2(SEQ_LEN);
  localparam int XW = (AW + 1 > lik_pkg::END_W) ? AW + 1 : lik_pkg::END_W;
  localparam logic [XW-1:0] SEQ_LEN_X = XW'(SEQ_LEN);

  lik_pkg::state_t     state_r, state_nxt;
  lik_pkg::in_req_t    req_r, req_nxt;
  logic [XW-1:0]       ptr_r, ptr_nxt;
  logic [XW-1:0]       chk_pos_r, chk_pos_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [XW-1:0]       lo_r, lo_nxt;
  logic [XW-1:0]       hi_r, hi_nxt;
  logic [lik_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                clr_rsp_r, clr_rsp_nxt;
  logic                out_valid_r, out_valid_nxt;
  lik_pkg::out_rsp_t   out_rsp_r, out_rsp_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  lik_pkg::map_entry_t mem_wdata;
  logic [AW-1:0]       mem_raddr;
  lik_pkg::map_entry_t mem_rdata;
  lik_pkg::map_entry_t new_entry;

  logic [XW-1:0]       in_nb_x, in_ne_x, in_q_x;
  logic [XW-1:0]       nb_x, ne_x;
  logic [lik_pkg::END_W-1:0] new_len, old_len;
  logic                in_bad;

  lik_owner_map #(
    .DEPTH (SEQ_LEN),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_nb_x = XW'(in_req.interval_begin);
  assign in_ne_x = XW'(in_req.interval_end);
  assign in_q_x  = XW'(in_req.query_position);
  assign in_bad  = (in_nb_x >= in_ne_x) || (in_ne_x > SEQ_LEN_X);

  assign nb_x    = XW'(req_r.interval_begin);
  assign ne_x    = XW'(req_r.interval_end);
  assign new_len = req_r.interval_end - {1'b0, req_r.interval_begin};
  assign old_len = mem_rdata.past - {1'b0, mem_rdata.first};

  always_comb begin
    new_entry        = '0;
    new_entry.valid  = 1'b1;
    new_entry.first  = req_r.interval_begin;
    new_entry.past   = req_r.interval_end;
    new_entry.phase  = req_r.reading_phase;
    new_entry.strand = req_r.strand_reverse;
    new_entry.score  = req_r.orf_score;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    chk_pos_nxt   = chk_pos_r;
    chk_vld_nxt   = 1'b0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    clr_rsp_nxt   = clr_rsp_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r[AW-1:0];
    mem_wdata     = '0;
    mem_raddr     = ptr_r[AW-1:0];

    case (state_r)
      lik_pkg::S_IDLE: begin
        mem_raddr = in_q_x[AW-1:0];
        if (start) begin
          req_nxt = in_req;
          case (in_req.opcode)
            lik_pkg::OP_CLEAR: begin
              state_nxt   = lik_pkg::S_SWEEP;
              ptr_nxt     = '0;
              clr_rsp_nxt = 1'b1;
            end
            lik_pkg::OP_INSERT: begin
              if (in_bad) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = lik_pkg::STAT_BAD_RANGE;
              end else begin
                state_nxt = lik_pkg::S_CHECK;
                ptr_nxt   = in_nb_x;
                lo_nxt    = in_nb_x;
                hi_nxt    = in_ne_x;
                cnt_nxt   = '0;
              end
            end
            default: begin
              if (in_q_x >= SEQ_LEN_X) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = lik_pkg::STAT_QUERY;
              end else begin
                state_nxt = lik_pkg::S_QUERY;
              end
            end
          endcase
        end
      end

      lik_pkg::S_QUERY: begin
        out_valid_nxt          = 1'b1;
        out_rsp_nxt.status     = lik_pkg::STAT_QUERY;
        if (mem_rdata.valid) begin
          out_rsp_nxt.owner_valid  = 1'b1;
          out_rsp_nxt.owner_begin  = mem_rdata.first;
          out_rsp_nxt.owner_end    = mem_rdata.past;
          out_rsp_nxt.owner_phase  = mem_rdata.phase;
          out_rsp_nxt.owner_strand = mem_rdata.strand;
          out_rsp_nxt.owner_score  = mem_rdata.score;
        end
        state_nxt = lik_pkg::S_IDLE;
      end

      lik_pkg::S_CHECK: begin
        if (ptr_r < ne_x) begin
          ptr_nxt     = ptr_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_pos_nxt = ptr_r;
        end
        if (chk_vld_r) begin
          if (mem_rdata.valid && (old_len > new_len)) begin
            out_valid_nxt      = 1'b1;
            out_rsp_nxt.status = lik_pkg::STAT_REJECTED;
            chk_vld_nxt        = 1'b0;
            state_nxt          = lik_pkg::S_IDLE;
          end else begin
            if (mem_rdata.valid && ((chk_pos_r == nb_x) ||
                                    (XW'(mem_rdata.first) == chk_pos_r))) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            if (mem_rdata.valid && (chk_pos_r == nb_x)) begin
              lo_nxt = XW'(mem_rdata.first);
            end
            if (mem_rdata.valid && (chk_pos_r == ne_x - 1'b1)) begin
              hi_nxt = XW'(mem_rdata.past);
            end
            if (chk_pos_r == ne_x - 1'b1) begin
              chk_vld_nxt = 1'b0;
              ptr_nxt     = lo_nxt;
              state_nxt   = lik_pkg::S_WRITE;
            end
          end
        end
      end

      lik_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = ((ptr_r >= nb_x) && (ptr_r < ne_x)) ? new_entry : '0;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == hi_r - 1'b1) begin
          out_valid_nxt             = 1'b1;
          out_rsp_nxt.status        = lik_pkg::STAT_ACCEPTED;
          out_rsp_nxt.evicted_count = cnt_r;
          state_nxt                 = lik_pkg::S_IDLE;
        end
      end

      lik_pkg::S_SWEEP: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == SEQ_LEN_X - 1'b1) begin
          if (clr_rsp_r) begin
            out_valid_nxt      = 1'b1;
            out_rsp_nxt.status = lik_pkg::STAT_CLEARED;
          end
          clr_rsp_nxt = 1'b0;
          state_nxt   = lik_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lik_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lik_pkg::S_SWEEP;
      ptr_r       <= '0;
      chk_vld_r   <= 1'b0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    chk_pos_r <= chk_pos_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    cnt_r     <= cnt_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != lik_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== rtl/lik_checker.sv =====
// Port-level checks for the interval keeper, bound to the top level.
`include "longest_interval_keeper_assert.svh"

module lik_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input lik_pkg::out_rsp_t out_rsp
);

  logic accept;
  logic rsp_not_query;
  logic rsp_not_accepted;
  logic owner_fields_zero;

  assign accept            = start && !busy;
  assign rsp_not_query     = out_valid && (out_rsp.status != lik_pkg::STAT_QUERY);
  assign rsp_not_accepted  = out_valid && (out_rsp.status != lik_pkg::STAT_ACCEPTED);
  assign owner_fields_zero = (out_rsp.owner_begin == '0) && (out_rsp.owner_end == '0) &&
                             (out_rsp.owner_phase == '0) && (out_rsp.owner_strand == 1'b0) &&
                             (out_rsp.owner_score == '0);

  `LIK_ASSERT_ALWAYS(a_reset_sweeps, clk, !rst_n |=> busy)
  `LIK_ASSERT(a_accept_progress, clk, rst_n, accept |=> (out_valid || busy))
  `LIK_ASSERT(a_owner_only_query, clk, rst_n, rsp_not_query |-> !out_rsp.owner_valid)
  `LIK_ASSERT(a_empty_owner_zero, clk, rst_n, (out_valid && !out_rsp.owner_valid) |-> owner_fields_zero)
  `LIK_ASSERT(a_no_evict_count, clk, rst_n, rsp_not_accepted |-> (out_rsp.evicted_count == '0))

endmodule

bind longest_interval_keeper lik_checker u_lik_checker (.*);

// ===== tb/sv/tb_longest_interval_keeper.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the longest interval keeper: directed and random requests.
module tb_longest_interval_keeper;

  localparam int SEQ_LEN = 4096;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  lik_pkg::in_req_t  in_req;
  logic              out_valid;
  lik_pkg::out_rsp_t out_rsp;

  longest_interval_keeper #(
    .SEQ_LEN(SEQ_LEN)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_rsp(out_rsp)
  );

  lik_pkg::map_entry_t owner_tbl [SEQ_LEN];
  lik_pkg::out_rsp_t   awaited_rsp_q [$];
  int                  mismatch_count = 0;
  int                  rsp_seen = 0;
  int                  burst_left = 1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Owner map predictor: applies one request and returns the response it causes.
  function automatic lik_pkg::out_rsp_t apply_interval_op(input lik_pkg::in_req_t req);
    lik_pkg::out_rsp_t rsp;
    int unsigned       nb, ne, len, evicted, i, j;
    bit                rejected;
    rsp = '0;
    nb = req.interval_begin;
    ne = req.interval_end;
    case (req.opcode)
      lik_pkg::OP_CLEAR: begin
        foreach (owner_tbl[k]) owner_tbl[k].valid = 1'b0;
        rsp.status = lik_pkg::STAT_CLEARED;
      end
      lik_pkg::OP_INSERT: begin
        if (nb >= ne || ne > SEQ_LEN) begin
          rsp.status = lik_pkg::STAT_BAD_RANGE;
        end else begin
          len = ne - nb;
          rejected = 1'b0;
          for (i = nb; i < ne; i++)
            if (owner_tbl[i].valid && (owner_tbl[i].past - owner_tbl[i].first) > len)
              rejected = 1'b1;
          if (rejected) begin
            rsp.status = lik_pkg::STAT_REJECTED;
          end else begin
            evicted = 0;
            for (i = nb; i < ne; i++) begin
              if (owner_tbl[i].valid) begin
                // whole evicted interval goes, including any overhang
                for (j = owner_tbl[i].first; j < owner_tbl[i].past && j < SEQ_LEN; j++)
                  owner_tbl[j].valid = 1'b0;
                evicted++;
              end
              owner_tbl[i].valid  = 1'b1;
              owner_tbl[i].first  = nb[lik_pkg::BEGIN_W-1:0];
              owner_tbl[i].past   = ne[lik_pkg::END_W-1:0];
              owner_tbl[i].phase  = req.reading_phase;
              owner_tbl[i].strand = req.strand_reverse;
              owner_tbl[i].score  = req.orf_score;
            end
            rsp.status        = lik_pkg::STAT_ACCEPTED;
            rsp.evicted_count = evicted[lik_pkg::COUNT_W-1:0];
          end
        end
      end
      default: begin
        rsp.status = lik_pkg::STAT_QUERY;
        if (req.query_position < SEQ_LEN && owner_tbl[req.query_position].valid) begin
          rsp.owner_valid  = 1'b1;
          rsp.owner_begin  = owner_tbl[req.query_position].first;
          rsp.owner_end    = owner_tbl[req.query_position].past;
          rsp.owner_phase  = owner_tbl[req.query_position].phase;
          rsp.owner_strand = owner_tbl[req.query_position].strand;
          rsp.owner_score  = owner_tbl[req.query_position].score;
        end
      end
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("response %0d %s: got %0h, want %0h",
                                rsp_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    lik_pkg::out_rsp_t want;
    if (rst_n && out_valid) begin
      rsp_seen++;
      if (awaited_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response %0d with no request pending", rsp_seen));
      end else begin
        want = awaited_rsp_q.pop_front();
        check_field("status", out_rsp.status, want.status);
        check_field("evicted_count", out_rsp.evicted_count, want.evicted_count);
        check_field("owner_valid", out_rsp.owner_valid, want.owner_valid);
        check_field("owner_begin", out_rsp.owner_begin, want.owner_begin);
        check_field("owner_end", out_rsp.owner_end, want.owner_end);
        check_field("owner_phase", out_rsp.owner_phase, want.owner_phase);
        check_field("owner_strand", out_rsp.owner_strand, want.owner_strand);
        check_field("owner_score", out_rsp.owner_score, want.owner_score);
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepted the request, or after a random idle gap that follows it.
  task automatic send_req(input lik_pkg::in_req_t req);
    int gap;
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_rsp_q.push_back(apply_interval_op(req));
    burst_left--;
    if (burst_left <= 0) begin
      case ($urandom_range(0, 2))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 8);
        default: gap = $urandom_range(9, 200);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic drain_all();
    start <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Unused fields carry random junk.
  function automatic lik_pkg::in_req_t junk_req();
    lik_pkg::in_req_t req;
    logic [63:0]      rnd;
    rnd = {$urandom, $urandom};
    req.opcode         = lik_pkg::OP_QUERY;
    req.interval_begin = rnd[11:0];
    req.interval_end   = rnd[24:12];
    req.reading_phase  = rnd[26:25];
    req.strand_reverse = rnd[27];
    req.query_position = rnd[39:28];
    req.orf_score      = $urandom;
    return req;
  endfunction

  task automatic send_insert(input int b, input int e, input logic [1:0] phase,
                             input logic strand, input logic [31:0] score);
    lik_pkg::in_req_t req;
    req = junk_req();
    req.opcode         = lik_pkg::OP_INSERT;
    req.interval_begin = b[lik_pkg::BEGIN_W-1:0];
    req.interval_end   = e[lik_pkg::END_W-1:0];
    req.reading_phase  = phase;
    req.strand_reverse = strand;
    req.orf_score      = score;
    send_req(req);
  endtask

  task automatic send_random_insert(input int b, input int e);
    logic [31:0] rnd;
    rnd = $urandom;
    send_insert(b, e, rnd[1:0], rnd[2], $urandom);
  endtask

  task automatic send_query(input int pos, input logic [1:0] op);
    lik_pkg::in_req_t req;
    req = junk_req();
    req.opcode         = op;
    req.query_position = pos[lik_pkg::BEGIN_W-1:0];
    send_req(req);
  endtask

  task automatic send_clear();
    lik_pkg::in_req_t req;
    req = junk_req();
    req.opcode = lik_pkg::OP_CLEAR;
    send_req(req);
  endtask

  task automatic test_reset_state();
    send_query(0, lik_pkg::OP_QUERY);
    send_query(SEQ_LEN - 1, lik_pkg::OP_QUERY);
  endtask

  task automatic test_longest_wins();
    send_insert(0, SEQ_LEN, 2'd3, 1'b1, 32'h8000_0000);
    send_query(SEQ_LEN - 1, lik_pkg::OP_QUERY);
    send_random_insert(10, 20);
  endtask

  task automatic test_equal_length_replace();
    send_insert(0, SEQ_LEN, 2'd0, 1'b0, 32'h7fff_ffff);
    send_query(0, lik_pkg::OP_QUERY);
  endtask

  task automatic test_clear();
    send_clear();
    send_query(2048, lik_pkg::OP_QUERY);
  endtask

  task automatic test_bad_ranges();
    send_random_insert(5, 5);
    send_random_insert(100, 50);
    send_random_insert(0, SEQ_LEN + 1);
    send_random_insert(SEQ_LEN - 1, 8191);
  endtask

  task automatic test_eviction_overhang();
    send_random_insert(100, 110);
    send_random_insert(110, 120);
    send_random_insert(95, 125);
    send_random_insert(120, 130);
    send_random_insert(90, 95);
    send_query(94, lik_pkg::OP_QUERY);
    send_random_insert(200, 220);
    send_random_insert(210, 230);
    send_query(205, lik_pkg::OP_QUERY);
  endtask

  task automatic test_map_edges();
    send_random_insert(SEQ_LEN - 1, SEQ_LEN);
    send_random_insert(0, 1);
    send_query(SEQ_LEN - 1, lik_pkg::OP_QUERY_ALT);
  endtask

  task automatic test_random_traffic(input int n_reqs);
    int pick, b, e, len;
    for (int n = 0; n < n_reqs; n++) begin
      if (n == n_reqs / 2) drain_all();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        b = $urandom_range(0, 1023);
        send_random_insert(b, b + $urandom_range(1, 64));
      end else if (pick < 54) begin
        b = $urandom_range(0, SEQ_LEN - 1);
        e = b + $urandom_range(1, 64);
        send_random_insert(b, (e > SEQ_LEN) ? SEQ_LEN : e);
      end else if (pick < 56) begin
        len = $urandom_range(65, SEQ_LEN);
        b = $urandom_range(0, SEQ_LEN - len);
        send_random_insert(b, b + len);
      end else if (pick < 60) begin
        b = $urandom_range(0, SEQ_LEN - 1);
        if ($urandom_range(0, 1))
          send_random_insert(b, $urandom_range(0, b));
        else
          send_random_insert(b, $urandom_range(SEQ_LEN + 1, 8191));
      end else if (pick < 61) begin
        send_clear();
      end else if (pick < 63) begin
        send_query($urandom_range(0, SEQ_LEN - 1), lik_pkg::OP_QUERY_ALT);
      end else if (pick < 90) begin
        send_query($urandom_range(0, 1100), lik_pkg::OP_QUERY);
      end else begin
        send_query($urandom_range(0, SEQ_LEN - 1), lik_pkg::OP_QUERY);
      end
    end
  endtask

  initial begin
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    foreach (owner_tbl[k]) owner_tbl[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_longest_wins();
    test_equal_length_replace();
    test_clear();
    test_bad_ranges();
    test_eviction_overhang();
    test_map_edges();
    drain_all();
    test_random_traffic(1000);

    drain_all();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_rsp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
